FILE: src/tzse_pkg.sv
// ----------------------------------------------------------------------------
// Zero-set extractor package
// Shared widths, codes, chain token types and helper functions.
// ----------------------------------------------------------------------------
package tzse_pkg;

	localparam int EDGE_TABLE_DEPTH = 4096;
	localparam int VID_BITS = 20;
	localparam int COORD_BITS = 20;
	localparam int OUT_BITS = 21;
	localparam int OVC_BITS = 21;
	localparam int KIND_BITS = 3;
	localparam int POS_BITS = 60;
	localparam int ERR_BITS = 2;

	localparam int IDX_BITS = $clog2(EDGE_TABLE_DEPTH);
	localparam int CNT_BITS = IDX_BITS + 1;
	localparam int CELL_BITS = (IDX_BITS + 1) / 2;
	localparam int CELLS = 1 << CELL_BITS;
	localparam int ROW_BITS = IDX_BITS - CELL_BITS;
	localparam int ROWS = 1 << ROW_BITS;
	localparam int NROW_BITS = ROW_BITS + 1;
	localparam int PAIR_BITS = 2 * VID_BITS;

	localparam int DIFF_BITS = COORD_BITS + 2;
	localparam int SQ_BITS = 2 * DIFF_BITS;
	localparam int ACC_BITS = SQ_BITS + 2;

	localparam logic [KIND_BITS-1:0] KIND_BOX = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_OUTER = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_INNER = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_ZERO = 3'd3;

	localparam logic [ERR_BITS-1:0] ERR_OK = 2'd0;
	localparam logic [ERR_BITS-1:0] ERR_TYPE = 2'd1;
	localparam logic [ERR_BITS-1:0] ERR_FULL = 2'd2;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_OVC = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_LOOK,
		ST_RES,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		EK_ERR_TYPE,
		EK_ERR_FULL,
		EK_PASS,
		EK_TRI2,
		EK_TRI1,
		EK_SPL6,
		EK_SPL4
	} emit_kind_t;

	typedef struct packed {
		logic vld;
		logic [VID_BITS-1:0] ka;
		logic [VID_BITS-1:0] kb;
		logic [ROW_BITS-1:0] row;
		logic hit;
		logic [IDX_BITS-1:0] idx;
	} tok_t;

	typedef struct packed {
		logic en;
		logic [CELL_BITS-1:0] bank;
		logic [ROW_BITS-1:0] row;
		logic [PAIR_BITS-1:0] data;
	} wr_t;

	function automatic logic signed [COORD_BITS-1:0] coord(
		input logic [POS_BITS-1:0] pos,
		input logic [1:0] axis
	);
		logic [POS_BITS-1:0] sh;
		sh = pos >> (axis * COORD_BITS);
		return signed'(sh[COORD_BITS-1:0]);
	endfunction

endpackage

FILE: src/tzse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tzse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/tzse_cell.sv
// ----------------------------------------------------------------------------
// Edge table search cell
// Holds one bank of the edge table and compares a passing search request
// against the entry of its row, then hands the request to its neighbor.
// ----------------------------------------------------------------------------
module tzse_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tzse_pkg::CELL_BITS-1:0] cell_index,
	input  logic [tzse_pkg::CNT_BITS-1:0]  count,
	input  tzse_pkg::wr_t                  wr,
	input  tzse_pkg::tok_t                 tok_in,
	output tzse_pkg::tok_t                 tok_out
);
	import tzse_pkg::*;

	tok_t tok_q;
	logic [PAIR_BITS-1:0] entry;
	logic [VID_BITS-1:0] ea, eb;
	logic live, match;

	tzse_ram #(.WIDTH(PAIR_BITS), .DEPTH(ROWS)) u_ram (
		.clk   (clk),
		.we    (wr.en && (wr.bank == cell_index)),
		.waddr (wr.row),
		.wdata (wr.data),
		.raddr (tok_in.row),
		.rdata (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_comb begin
		ea = entry[VID_BITS-1:0];
		eb = entry[PAIR_BITS-1:VID_BITS];
		live = CNT_BITS'({tok_q.row, cell_index}) < count;
		match = live && (((ea == tok_q.ka) && (eb == tok_q.kb)) ||
			((ea == tok_q.kb) && (eb == tok_q.ka)));
		tok_out = tok_q;
		if (tok_q.vld && match) begin
			tok_out.hit = 1'b1;
			tok_out.idx = {tok_q.row, cell_index};
		end
	end
endmodule

FILE: src/tetra_zero_set_extractor.sv
// ----------------------------------------------------------------------------
// Tetrahedron zero-set extractor
// Splits each tetrahedron's corners by sign, finds or appends the crossing
// edges in an edge table searched by a chain of cells, and emits zero-set
// triangles or split tetrahedra; uniform ones pass through in split mode.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    tdata ids+positions, tuser kinds
//   m_       out        m_tvalid/m_tready    tdata vertices, tuser error, tlast
//   cfg_     in         cfg_we               cfg_index, cfg_data
//
// One item at a time. Each edge lookup sweeps the rows of the table through the
// 64-cell search chain; an item with corners on both sides does 3 or 4 lookups,
// after a diagonal compare when two corners are inner in triangle mode, and
// then emits its results in turn.
// Reset clears the edge count; the table itself is never cleared.
// A stalled output holds its request; the next item is taken once the last
// result sits in the output register.
// ----------------------------------------------------------------------------
module tetra_zero_set_extractor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [319:0] s_tdata,  // corner_id_0..3, corner_pos_0..3
	input  logic [11:0]  s_tuser,  // corner_kind_0..3
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // out_vertex_0..3, zero fill
	output logic [1:0]   m_tuser,  // error_code
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [20:0]  cfg_data
);
	import tzse_pkg::*;

	state_t state_q, state_d;
	emit_kind_t kind_q;

	logic mode_q;
	logic [OVC_BITS-1:0] ovc_q;
	logic [CNT_BITS-1:0] count_q;

	logic [VID_BITS-1:0] id_q [4];
	logic [VID_BITS-1:0] in_q [4];
	logic [VID_BITS-1:0] out_q [4];
	logic [POS_BITS-1:0] pin_q [2];
	logic [POS_BITS-1:0] pout_q [2];
	logic [2:0] ni_q;

	logic [VID_BITS-1:0] c_id [4];
	logic [VID_BITS-1:0] c_in [4];
	logic [VID_BITS-1:0] c_out [4];
	logic [POS_BITS-1:0] c_pin [2];
	logic [POS_BITS-1:0] c_pout [2];
	logic [2:0] c_ni, c_no;
	logic [1:0] c_sg [4];
	logic [KIND_BITS-1:0] c_kind;
	logic c_bad, c_uni;

	logic [1:0] ax_q;
	logic [SQ_BITS-1:0] pu_s1, pw_s1;
	logic [ACC_BITS-1:0] dac_q, dbd_q, dac_sum, dbd_sum;
	logic signed [DIFF_BITS-1:0] du, dw;
	logic swap_q;

	logic [1:0] j_q, jj;
	logic [NROW_BITS-1:0] nrows_q, iss_q, ret_q;
	logic hit_q, full_q;
	logic [IDX_BITS-1:0] hidx_q;
	logic [IDX_BITS-1:0] lk_q [4];
	logic [CNT_BITS+CELL_BITS-1:0] row_sum;

	tok_t tok_c [CELLS+1];
	wr_t wr;

	logic [2:0] k_q, nres;
	logic [OUT_BITS-1:0] v [4];
	logic [OUT_BITS-1:0] e, f, g, h, a, b, c, d;

	logic accept, last_lk, emit_load, emit_last;

	assign accept = s_tvalid && s_tready;
	assign last_lk = (ni_q == 3'd2) ? (j_q == 2'd3) : (j_q == 2'd2);
	assign emit_load = (state_q == ST_EMIT) && (!m_tvalid || m_tready);
	assign emit_last = (k_q == nres - 3'd1);

	// Corner classification.
	always_comb begin
		c_ni = '0;
		c_no = '0;
		c_bad = 1'b0;
		for (int n = 0; n < 4; n++) begin
			c_in[n] = '0;
			c_out[n] = '0;
		end
		for (int n = 0; n < 2; n++) begin
			c_pin[n] = '0;
			c_pout[n] = '0;
		end
		for (int n = 0; n < 4; n++) begin
			c_id[n] = s_tdata[n*VID_BITS +: VID_BITS];
			c_kind = s_tuser[n*KIND_BITS +: KIND_BITS];
			if (c_kind > KIND_ZERO) c_bad = 1'b1;
			c_sg[n] = (c_kind == KIND_INNER) ? 2'd2 : ((c_kind == KIND_ZERO) ? 2'd0 : 2'd1);
			if (c_kind == KIND_INNER) begin
				c_in[c_ni[1:0]] = c_id[n];
				if (c_ni < 3'd2) c_pin[c_ni[0]] = s_tdata[4*VID_BITS + n*POS_BITS +: POS_BITS];
				c_ni = c_ni + 3'd1;
			end else begin
				c_out[c_no[1:0]] = c_id[n];
				if (c_no < 3'd2) c_pout[c_no[0]] = s_tdata[4*VID_BITS + n*POS_BITS +: POS_BITS];
				c_no = c_no + 3'd1;
			end
		end
		c_uni = (c_sg[0] == c_sg[1]) && (c_sg[0] == c_sg[2]) && (c_sg[0] == c_sg[3]);
	end

	// Diagonal lengths, one axis a cycle.
	always_comb begin
		du = DIFF_BITS'(coord(pin_q[0], ax_q)) + DIFF_BITS'(coord(pout_q[0], ax_q))
			- DIFF_BITS'(coord(pin_q[1], ax_q)) - DIFF_BITS'(coord(pout_q[1], ax_q));
		dw = DIFF_BITS'(coord(pin_q[0], ax_q)) + DIFF_BITS'(coord(pout_q[1], ax_q))
			- DIFF_BITS'(coord(pin_q[1], ax_q)) - DIFF_BITS'(coord(pout_q[0], ax_q));
		dac_sum = dac_q + ACC_BITS'(pu_s1);
		dbd_sum = dbd_q + ACC_BITS'(pw_s1);
	end

	assign jj = swap_q ? (j_q ^ {1'b0, j_q[1]}) : j_q;
	assign row_sum = (CNT_BITS+CELL_BITS)'(count_q) + (CNT_BITS+CELL_BITS)'(CELLS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (c_bad) state_d = ST_EMIT;
					else if (c_uni) state_d = mode_q ? ST_EMIT : ST_IDLE;
					else if (c_ni == 3'd0) state_d = ST_IDLE;
					else if (!mode_q && (c_ni == 3'd2)) state_d = ST_DIST;
					else state_d = ST_LOOK;
				end
			end
			ST_DIST: if (ax_q == 2'd3) state_d = ST_LOOK;
			ST_LOOK: if (ret_q == nrows_q) state_d = ST_RES;
			ST_RES: state_d = last_lk ? ST_EMIT : ST_LOOK;
			ST_EMIT: if (emit_load && emit_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		tok_c[0].vld = (state_q == ST_LOOK) && (iss_q < nrows_q);
		tok_c[0].row = iss_q[ROW_BITS-1:0];
		tok_c[0].hit = 1'b0;
		tok_c[0].idx = '0;
		if (ni_q == 3'd2) begin
			tok_c[0].ka = in_q[{1'b0, jj[1]}];
			tok_c[0].kb = out_q[{1'b0, jj[0]}];
		end else if (ni_q == 3'd1) begin
			tok_c[0].ka = in_q[0];
			tok_c[0].kb = out_q[j_q];
		end else begin
			tok_c[0].ka = in_q[j_q];
			tok_c[0].kb = out_q[0];
		end
		wr.en = (state_q == ST_RES) && !hit_q && (count_q != CNT_BITS'(EDGE_TABLE_DEPTH));
		wr.bank = count_q[CELL_BITS-1:0];
		wr.row = count_q[IDX_BITS-1:CELL_BITS];
		wr.data = {tok_c[0].kb, tok_c[0].ka};
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		tzse_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (CELL_BITS'(i)),
			.count      (count_q),
			.wr         (wr),
			.tok_in     (tok_c[i]),
			.tok_out    (tok_c[i+1])
		);
	end

	// Result vertex selection.
	always_comb begin
		e = OUT_BITS'(lk_q[0]) + ovc_q;
		f = OUT_BITS'(lk_q[1]) + ovc_q;
		g = OUT_BITS'(lk_q[2]) + ovc_q;
		h = OUT_BITS'(lk_q[3]) + ovc_q;
		if (ni_q == 3'd2) begin
			a = OUT_BITS'(in_q[0]);
			b = OUT_BITS'(in_q[1]);
			c = OUT_BITS'(out_q[0]);
			d = OUT_BITS'(out_q[1]);
		end else if (ni_q == 3'd1) begin
			a = OUT_BITS'(in_q[0]);
			b = OUT_BITS'(out_q[0]);
			c = OUT_BITS'(out_q[1]);
			d = OUT_BITS'(out_q[2]);
		end else begin
			a = OUT_BITS'(out_q[0]);
			b = OUT_BITS'(in_q[0]);
			c = OUT_BITS'(in_q[1]);
			d = OUT_BITS'(in_q[2]);
		end
		for (int n = 0; n < 4; n++) v[n] = '0;
		nres = 3'd1;
		case (kind_q)
			EK_PASS: begin
				for (int n = 0; n < 4; n++) v[n] = OUT_BITS'(id_q[n]);
			end
			EK_TRI1: begin
				v[0] = OUT_BITS'(lk_q[0]);
				v[1] = OUT_BITS'(lk_q[1]);
				v[2] = OUT_BITS'(lk_q[2]);
			end
			EK_TRI2: begin
				nres = 3'd2;
				v[0] = (k_q == 3'd0 || !swap_q) ? OUT_BITS'(lk_q[{1'b0, k_q[0]}]) :
					OUT_BITS'(lk_q[0]);
				v[1] = OUT_BITS'(lk_q[k_q[0] ? 2'd2 : 2'd1]);
				if (swap_q) v[1] = OUT_BITS'(lk_q[k_q[0] ? 2'd2 : 2'd1]);
				v[2] = OUT_BITS'(lk_q[k_q[0] ? 2'd3 : 2'd2]);
				if (!swap_q && k_q[0]) begin
					v[0] = OUT_BITS'(lk_q[1]);
					v[1] = OUT_BITS'(lk_q[2]);
				end
			end
			EK_SPL6: begin
				nres = 3'd6;
				case (k_q)
					3'd0: begin v[0] = a; v[1] = b; v[2] = e; v[3] = f; end
					3'd1: begin v[0] = b; v[1] = e; v[2] = f; v[3] = h; end
					3'd2: begin v[0] = d; v[1] = e; v[2] = f; v[3] = h; end
					3'd3: begin v[0] = c; v[1] = d; v[2] = e; v[3] = g; end
					3'd4: begin v[0] = b; v[1] = e; v[2] = g; v[3] = h; end
					default: begin v[0] = d; v[1] = e; v[2] = g; v[3] = h; end
				endcase
			end
			EK_SPL4: begin
				nres = 3'd4;
				case (k_q)
					3'd0: begin v[0] = a; v[1] = e; v[2] = f; v[3] = g; end
					3'd1: begin v[0] = d; v[1] = e; v[2] = f; v[3] = g; end
					3'd2: begin v[0] = b; v[1] = c; v[2] = d; v[3] = e; end
					default: begin v[0] = c; v[1] = d; v[2] = e; v[3] = f; end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= EK_PASS;
			mode_q <= 1'b0;
			ovc_q <= '0;
			count_q <= '0;
			m_tvalid <= 1'b0;
			ax_q <= '0;
			j_q <= '0;
			k_q <= '0;
			iss_q <= '0;
			ret_q <= '0;
			nrows_q <= '0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
			swap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_MODE) begin
					mode_q <= cfg_data[0];
					if (!cfg_data[0]) count_q <= '0;
				end else begin
					ovc_q <= cfg_data;
				end
			end
			if (m_tvalid && m_tready && !emit_load) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					ax_q <= '0;
					j_q <= '0;
					k_q <= '0;
					full_q <= 1'b0;
					swap_q <= 1'b0;
					iss_q <= '0;
					ret_q <= '0;
					hit_q <= 1'b0;
					nrows_q <= NROW_BITS'(row_sum >> CELL_BITS);
					if (c_bad) kind_q <= EK_ERR_TYPE;
					else if (c_uni) kind_q <= EK_PASS;
					else if (!mode_q) kind_q <= (c_ni == 3'd2) ? EK_TRI2 : EK_TRI1;
					else kind_q <= (c_ni == 3'd2) ? EK_SPL6 : EK_SPL4;
				end
				ST_DIST: begin
					ax_q <= ax_q + 2'd1;
					if (ax_q == 2'd3 && (dac_sum < dbd_sum)) swap_q <= 1'b1;
				end
				ST_LOOK: begin
					if (tok_c[0].vld) iss_q <= iss_q + NROW_BITS'(1);
					if (tok_c[CELLS].vld) begin
						ret_q <= ret_q + NROW_BITS'(1);
						if (tok_c[CELLS].hit) begin
							hit_q <= 1'b1;
							hidx_q <= tok_c[CELLS].idx;
						end
					end
				end
				ST_RES: begin
					if (hit_q) begin
						lk_q[j_q] <= hidx_q;
					end else if (count_q == CNT_BITS'(EDGE_TABLE_DEPTH)) begin
						full_q <= 1'b1;
						lk_q[j_q] <= '0;
					end else begin
						lk_q[j_q] <= count_q[IDX_BITS-1:0];
						count_q <= count_q + CNT_BITS'(1);
					end
					j_q <= j_q + 2'd1;
					iss_q <= '0;
					ret_q <= '0;
					hit_q <= 1'b0;
					nrows_q <= NROW_BITS'((row_sum + (wr.en ? 1 : 0)) >> CELL_BITS);
					if (last_lk && (full_q || (!hit_q && !wr.en))) kind_q <= EK_ERR_FULL;
				end
				ST_EMIT: begin
					if (emit_load) begin
						m_tvalid <= 1'b1;
						k_q <= k_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ni_q <= c_ni;
			for (int n = 0; n < 4; n++) begin
				id_q[n] <= c_id[n];
				in_q[n] <= c_in[n];
				out_q[n] <= c_out[n];
			end
			for (int n = 0; n < 2; n++) begin
				pin_q[n] <= c_pin[n];
				pout_q[n] <= c_pout[n];
			end
		end
		if (state_q == ST_IDLE) begin
			dac_q <= '0;
			dbd_q <= '0;
			pu_s1 <= '0;
			pw_s1 <= '0;
		end else if (state_q == ST_DIST) begin
			pu_s1 <= SQ_BITS'(du * du);
			pw_s1 <= SQ_BITS'(dw * dw);
			dac_q <= dac_sum;
			dbd_q <= dbd_sum;
		end
		if (emit_load) begin
			m_tdata <= {4'b0, v[3], v[2], v[1], v[0]};
			m_tlast <= emit_last;
			m_tuser <= (kind_q == EK_ERR_TYPE) ? ERR_TYPE :
				((kind_q == EK_ERR_FULL) ? ERR_FULL : ERR_OK);
		end
	end
endmodule

FILE: src/tzse_checker.sv
// ----------------------------------------------------------------------------
// Zero-set extractor port checker
// Watches the top-level ports for result framing and error rules.
// ----------------------------------------------------------------------------
module tzse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import tzse_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output request dropped while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ERR_OK) |-> m_tlast)
		else $error("error result is not the last of its run");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ERR_OK) |-> (m_tdata == '0))
		else $error("error result carries vertices");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ERR_OK) || (m_tuser == ERR_TYPE) || (m_tuser == ERR_FULL))
		else $error("unknown error code");
endmodule

bind tetra_zero_set_extractor tzse_checker u_tzse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
